/* rtl/core/cldr_pkg.sv */
// Shared types, command codes and the LCD set-up table of the character LCD refresher.
package cldr_pkg;

    localparam int COLUMNS_DEF = 20;
    localparam int ROWS_DEF    = 2;

    localparam int STEP_W = 4;
    localparam int WAIT_W = 13;

    localparam logic [7:0] CHAR_SPACE      = 8'h20;
    localparam logic [7:0] CMD_SET_DDRAM   = 8'h80;
    localparam logic [7:0] DDRAM_ROW1      = 8'h40;
    localparam logic [7:0] CMD_SET_CGRAM   = 8'h40;
    localparam logic [7:0] CMD_CLEAR       = 8'h01;
    localparam logic [7:0] CMD_FUNC_8BIT   = 8'h30;
    localparam logic [7:0] CMD_FUNC_2LINE  = 8'h38;
    localparam logic [7:0] CMD_DISPLAY_OFF = 8'h08;
    localparam logic [7:0] CMD_ENTRY_MODE  = 8'h06;
    localparam logic [7:0] CMD_DISPLAY_ON  = 8'h0C;

    localparam logic [WAIT_W-1:0] WAIT_NORMAL   = 13'd40;
    localparam logic [WAIT_W-1:0] WAIT_CLEAR    = 13'd1640;
    localparam logic [WAIT_W-1:0] WAIT_POWER_UP = 13'd4100;
    localparam logic [WAIT_W-1:0] WAIT_SHORT    = 13'd100;

    localparam logic [STEP_W-1:0] INIT_CLEAR_STEP = 4'd6;
    localparam logic [STEP_W-1:0] INIT_LAST_STEP  = 4'd8;
    localparam logic [STEP_W-1:0] GLYPH_LAST_STEP = 4'd8;

    typedef enum logic [2:0] {
        OP_WRITE_CELL   = 3'd0,
        OP_REFRESH      = 3'd1,
        OP_UPLOAD_GLYPH = 3'd2,
        OP_CLEAR        = 3'd3,
        OP_INIT         = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ADDR,
        ST_CHAR,
        ST_GLYPH,
        ST_CLEAR,
        ST_INIT,
        ST_FLUSH
    } state_t;

    typedef enum logic [2:0] {
        EK_ADDR,
        EK_CHAR,
        EK_GLYPH,
        EK_CLEAR,
        EK_INIT
    } emit_kind_t;

    typedef struct packed {
        logic              cell_wr;
        logic              glyph_ld;
        logic              emit;
        emit_kind_t        kind;
        logic [STEP_W-1:0] step;
        logic              shadow_wr;
        logic              clear;
        logic              cursor_adv;
        logic              cursor_forget;
    } dp_cmd_t;

    typedef struct packed {
        logic diff;
        logic cursor_here;
    } dp_stat_t;

    typedef struct packed {
        logic [7:0]        lcd_byte;
        logic              is_data;
        logic [WAIT_W-1:0] wait_us;
    } lcd_word_t;

    // Power-on set-up sequence for an 8-bit bus; the clear sits at INIT_CLEAR_STEP.
    function automatic lcd_word_t init_word(input logic [STEP_W-1:0] step);
        lcd_word_t w;
        w.is_data = 1'b0;
        case (step)
            4'd0:    begin w.lcd_byte = CMD_FUNC_8BIT;   w.wait_us = WAIT_POWER_UP; end
            4'd1:    begin w.lcd_byte = CMD_FUNC_8BIT;   w.wait_us = WAIT_SHORT;    end
            4'd2:    begin w.lcd_byte = CMD_FUNC_8BIT;   w.wait_us = WAIT_POWER_UP; end
            4'd3:    begin w.lcd_byte = CMD_FUNC_2LINE;  w.wait_us = WAIT_NORMAL;   end
            4'd4:    begin w.lcd_byte = CMD_FUNC_2LINE;  w.wait_us = WAIT_NORMAL;   end
            4'd5:    begin w.lcd_byte = CMD_DISPLAY_OFF; w.wait_us = WAIT_NORMAL;   end
            4'd6:    begin w.lcd_byte = CMD_CLEAR;       w.wait_us = WAIT_CLEAR;    end
            4'd7:    begin w.lcd_byte = CMD_ENTRY_MODE;  w.wait_us = WAIT_NORMAL;   end
            default: begin w.lcd_byte = CMD_DISPLAY_ON;  w.wait_us = WAIT_NORMAL;   end
        endcase
        return w;
    endfunction

endpackage

/* rtl/core/cldr_dp.sv */
// Datapath: screen and shadow buffers, cursor tracking and LCD byte selection.
module cldr_dp
    import cldr_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF,
    localparam int NCELLS = ROWS * COLUMNS,
    localparam int AW     = (NCELLS > 1) ? $clog2(NCELLS) : 1,
    localparam int CIW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1,
    localparam int CW     = $clog2(COLUMNS + 1)
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  dp_cmd_t         cmd,
    input  logic [AW-1:0]   rd_addr,
    input  logic [AW-1:0]   scan_idx,
    input  logic            scan_row,
    input  logic [CIW-1:0]  scan_col,
    input  logic            in_row,
    input  logic [4:0]      in_column,
    input  logic [7:0]      in_char_code,
    input  logic [2:0]      in_glyph_index,
    input  logic [63:0]     in_glyph_rows,
    output dp_stat_t        stat,
    output lcd_word_t       word
);

    logic [7:0]        screen_mem_reg [NCELLS];
    logic [7:0]        shadow_mem_reg [NCELLS];
    logic [NCELLS-1:0] screen_vld_reg;
    logic [NCELLS-1:0] shadow_vld_reg;
    logic [7:0]        screen_rd_reg;
    logic [7:0]        shadow_rd_reg;
    logic              screen_rd_vld_reg;
    logic              shadow_rd_vld_reg;
    logic [CW-1:0]     cur_col_reg;
    logic              cur_row_reg;
    logic              cur_known_reg;
    logic [2:0]        glyph_idx_reg;
    logic [63:0]       glyph_rows_reg;

    logic              cell_in_range;
    logic [AW-1:0]     cell_addr;
    logic [7:0]        screen_cur;
    logic [7:0]        shadow_cur;
    logic [2:0]        glyph_sel;

    assign cell_in_range = (int'(in_row) < ROWS) && (int'(in_column) < COLUMNS);
    assign cell_addr     = AW'(int'(in_row) * COLUMNS + int'(in_column));

    // A cell that has not been written since the last clear reads as a space.
    assign screen_cur = screen_rd_vld_reg ? screen_rd_reg : CHAR_SPACE;
    assign shadow_cur = shadow_rd_vld_reg ? shadow_rd_reg : CHAR_SPACE;

    assign stat.diff        = (screen_cur != shadow_cur);
    assign stat.cursor_here = cur_known_reg && (cur_col_reg == CW'(scan_col))
                              && (cur_row_reg == scan_row);

    always_ff @(posedge clk) begin
        if (cmd.cell_wr && cell_in_range) begin
            screen_mem_reg[cell_addr] <= in_char_code;
        end
        if (cmd.shadow_wr) begin
            shadow_mem_reg[scan_idx] <= screen_cur;
        end
        screen_rd_reg <= screen_mem_reg[rd_addr];
        shadow_rd_reg <= shadow_mem_reg[rd_addr];
        if (cmd.glyph_ld) begin
            glyph_idx_reg  <= in_glyph_index;
            glyph_rows_reg <= in_glyph_rows;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            screen_vld_reg    <= '0;
            shadow_vld_reg    <= '0;
            screen_rd_vld_reg <= 1'b0;
            shadow_rd_vld_reg <= 1'b0;
            cur_col_reg       <= '0;
            cur_row_reg       <= 1'b0;
            cur_known_reg     <= 1'b0;
        end
        else begin
            screen_rd_vld_reg <= screen_vld_reg[rd_addr];
            shadow_rd_vld_reg <= shadow_vld_reg[rd_addr];
            if (cmd.clear) begin
                screen_vld_reg <= '0;
                shadow_vld_reg <= '0;
                cur_col_reg    <= '0;
                cur_row_reg    <= 1'b0;
                cur_known_reg  <= 1'b1;
            end
            else begin
                if (cmd.cell_wr && cell_in_range) begin
                    screen_vld_reg[cell_addr] <= 1'b1;
                end
                if (cmd.shadow_wr) begin
                    shadow_vld_reg[scan_idx] <= 1'b1;
                end
                if (cmd.cursor_adv) begin
                    cur_col_reg   <= CW'(scan_col) + CW'(1);
                    cur_row_reg   <= scan_row;
                    cur_known_reg <= 1'b1;
                end
                else if (cmd.cursor_forget) begin
                    cur_known_reg <= 1'b0;
                end
            end
        end
    end

    assign glyph_sel = 3'(cmd.step - 1'b1);

    always_comb begin
        word.is_data = 1'b0;
        word.wait_us = WAIT_NORMAL;
        word.lcd_byte = CMD_CLEAR;
        case (cmd.kind)
            EK_ADDR: begin
                word.lcd_byte = CMD_SET_DDRAM + (scan_row ? DDRAM_ROW1 : 8'h00)
                                + 8'(scan_col);
            end
            EK_CHAR: begin
                word.lcd_byte = screen_cur;
                word.is_data  = 1'b1;
            end
            EK_GLYPH: begin
                if (cmd.step == '0) begin
                    word.lcd_byte = CMD_SET_CGRAM + {2'b00, glyph_idx_reg, 3'b000};
                end
                else begin
                    word.lcd_byte = glyph_rows_reg[{glyph_sel, 3'b000} +: 8];
                    word.is_data  = 1'b1;
                end
            end
            EK_CLEAR: begin
                word.lcd_byte = CMD_CLEAR;
                word.wait_us  = WAIT_CLEAR;
            end
            EK_INIT: begin
                word = init_word(cmd.step);
            end
            default: begin
                word.lcd_byte = CMD_CLEAR;
            end
        endcase
    end

endmodule

/* rtl/core/cldr_out.sv */
// Output stage: one pending word that learns its last flag, then the stream output register.
module cldr_out
    import cldr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        emit,
    input  logic        flush,
    input  lcd_word_t   word,
    output logic        room,
    input  logic        m_axis_tready,
    output logic        m_axis_tvalid,
    output logic [23:0] m_axis_tdata,   // lcd_byte[7:0], wait_us[20:8], zero fill
    output logic [0:0]  m_axis_tuser,   // is_data
    output logic        m_axis_tlast
);

    logic      pend_valid_reg;
    logic      pend_valid_next;
    lcd_word_t pend_word_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    lcd_word_t out_word_reg;
    logic      out_last_reg;
    logic      out_free;
    logic      move;

    always_comb begin
        out_free = !out_valid_reg || m_axis_tready;
        room     = !pend_valid_reg || out_free;
        // The pending word leaves when a newer word replaces it or the item closes.
        move     = pend_valid_reg && out_free && (emit || flush);
        pend_valid_next = pend_valid_reg;
        if (emit) begin
            pend_valid_next = 1'b1;
        end
        else if (move) begin
            pend_valid_next = 1'b0;
        end
        out_valid_next = out_free ? move : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (emit) begin
            pend_word_reg <= word;
        end
        if (move) begin
            out_word_reg <= pend_word_reg;
            out_last_reg <= flush;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_word_reg.wait_us, out_word_reg.lcd_byte};
    assign m_axis_tuser  = out_word_reg.is_data;
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_emit_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> room)
        else $error("word emitted while the output stage is full");

    a_emit_not_flush: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> !flush)
        else $error("emit and flush requested together");

    a_flush_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (flush && room) |=> !pend_valid_reg)
        else $error("pending word not drained at item close");

    a_emit_fills: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> pend_valid_reg)
        else $error("emitted word not held as pending");
`endif

endmodule

/* rtl/core/cldr_ctrl.sv */
// Controller: item decode, refresh scan sequencing and byte emission steps.
module cldr_ctrl
    import cldr_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF,
    localparam int NCELLS = ROWS * COLUMNS,
    localparam int AW     = (NCELLS > 1) ? $clog2(NCELLS) : 1,
    localparam int CIW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [2:0]      s_op,
    input  dp_stat_t        stat,
    input  logic            room,
    output dp_cmd_t         cmd,
    output logic            flush,
    output logic [AW-1:0]   rd_addr,
    output logic [AW-1:0]   scan_idx,
    output logic            scan_row,
    output logic [CIW-1:0]  scan_col
);

    state_t            state_reg, state_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic              row_reg, row_next;
    logic [CIW-1:0]    col_reg, col_next;
    logic [STEP_W-1:0] step_reg, step_next;

    logic              last_cell;
    logic [AW-1:0]     idx_inc;

    assign last_cell = (idx_reg == AW'(NCELLS - 1));
    assign idx_inc   = AW'(idx_reg + 1'b1);
    assign scan_idx  = idx_reg;
    assign scan_row  = row_reg;
    assign scan_col  = col_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            row_reg   <= 1'b0;
            col_reg   <= '0;
            step_reg  <= '0;
        end
        else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.kind   = EK_CHAR;
        cmd.step   = step_reg;
        flush      = 1'b0;
        s_ready    = 1'b0;
        rd_addr    = idx_reg;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                rd_addr = '0;
                if (s_valid) begin
                    case (op_t'(s_op))
                        OP_WRITE_CELL: begin
                            cmd.cell_wr = 1'b1;
                        end
                        OP_REFRESH: begin
                            idx_next   = '0;
                            row_next   = 1'b0;
                            col_next   = '0;
                            state_next = ST_SCAN;
                        end
                        OP_UPLOAD_GLYPH: begin
                            cmd.glyph_ld = 1'b1;
                            step_next    = '0;
                            state_next   = ST_GLYPH;
                        end
                        OP_CLEAR: begin
                            state_next = ST_CLEAR;
                        end
                        OP_INIT: begin
                            step_next  = '0;
                            state_next = ST_INIT;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                if (stat.diff) begin
                    state_next = stat.cursor_here ? ST_CHAR : ST_ADDR;
                end
                else if (last_cell) begin
                    state_next = ST_FLUSH;
                end
                else begin
                    rd_addr  = idx_inc;
                    idx_next = idx_inc;
                    if (col_reg == CIW'(COLUMNS - 1)) begin
                        col_next = '0;
                        row_next = 1'b1;
                    end
                    else begin
                        col_next = CIW'(col_reg + 1'b1);
                    end
                end
            end

            ST_ADDR: begin
                if (room) begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = EK_ADDR;
                    state_next = ST_CHAR;
                end
            end

            ST_CHAR: begin
                if (room) begin
                    cmd.emit       = 1'b1;
                    cmd.kind       = EK_CHAR;
                    cmd.shadow_wr  = 1'b1;
                    cmd.cursor_adv = 1'b1;
                    if (last_cell) begin
                        state_next = ST_FLUSH;
                    end
                    else begin
                        rd_addr    = idx_inc;
                        idx_next   = idx_inc;
                        state_next = ST_SCAN;
                        if (col_reg == CIW'(COLUMNS - 1)) begin
                            col_next = '0;
                            row_next = 1'b1;
                        end
                        else begin
                            col_next = CIW'(col_reg + 1'b1);
                        end
                    end
                end
            end

            ST_GLYPH: begin
                cmd.kind = EK_GLYPH;
                if (room) begin
                    cmd.emit = 1'b1;
                    if (step_reg == GLYPH_LAST_STEP) begin
                        cmd.cursor_forget = 1'b1;
                        state_next        = ST_FLUSH;
                    end
                    else begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end

            ST_CLEAR: begin
                cmd.kind = EK_CLEAR;
                if (room) begin
                    cmd.emit   = 1'b1;
                    cmd.clear  = 1'b1;
                    state_next = ST_FLUSH;
                end
            end

            ST_INIT: begin
                cmd.kind = EK_INIT;
                if (room) begin
                    cmd.emit  = 1'b1;
                    cmd.clear = (step_reg == INIT_CLEAR_STEP);
                    if (step_reg == INIT_LAST_STEP) begin
                        state_next = ST_FLUSH;
                    end
                    else begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end

            ST_FLUSH: begin
                flush = 1'b1;
                if (room) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/char_lcd_diff_refresher.sv */
// Top level of the character LCD refresher: input decode, controller, datapath, output stage.
//
//  Channel  | Direction | tdata (low bit up)                              | tuser   | tlast
//  ---------+-----------+-------------------------------------------------+---------+------
//  s_axis   | in        | row, column, char_code, glyph_index, glyph_rows | op      | -
//  m_axis   | out       | lcd_byte, wait_us                               | is_data | last
//
// A refresh walks the screen through one read port of the two cell buffers: an unchanged
// cell takes a scan step, a changed cell a scan step and a character step, with an address
// command step ahead of the character unless the cursor is known to be there already. A
// flush step closes a refresh, a glyph upload, a clear and an init.
// Reset clears the control state and the per-cell valid bits at once; no clearing pass.
// When the output side stalls, the controller holds in place until the output stage has
// room; the next word is accepted while the final result of the previous one waits.
module char_lcd_diff_refresher
    import cldr_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,   // row[0], column[5:1], char_code[13:6],
                                        // glyph_index[16:14], glyph_rows[80:17], zero fill
    input  logic [2:0]  s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // lcd_byte[7:0], wait_us[20:8], zero fill
    output logic [0:0]  m_axis_tuser,   // is_data
    output logic        m_axis_tlast
);

    localparam int NCELLS = ROWS * COLUMNS;
    localparam int AW     = (NCELLS > 1) ? $clog2(NCELLS) : 1;
    localparam int CIW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

    // Fields of the incoming word.
    logic        in_row;
    logic [4:0]  in_column;
    logic [7:0]  in_char_code;
    logic [2:0]  in_glyph_index;
    logic [63:0] in_glyph_rows;

    assign in_row         = s_axis_tdata[0];
    assign in_column      = s_axis_tdata[5:1];
    assign in_char_code   = s_axis_tdata[13:6];
    assign in_glyph_index = s_axis_tdata[16:14];
    assign in_glyph_rows  = s_axis_tdata[80:17];

    dp_cmd_t        cmd;
    dp_stat_t       stat;
    lcd_word_t      word;
    logic           room;
    logic           flush;
    logic [AW-1:0]  rd_addr;
    logic [AW-1:0]  scan_idx;
    logic           scan_row;
    logic [CIW-1:0] scan_col;

    // The controller sequences every item; it talks to the datapath through the command
    // and status structs, the read address and the scan position.
    cldr_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_valid  (s_axis_tvalid),
        .s_ready  (s_axis_tready),
        .s_op     (s_axis_tuser),
        .stat     (stat),
        .room     (room),
        .cmd      (cmd),
        .flush    (flush),
        .rd_addr  (rd_addr),
        .scan_idx (scan_idx),
        .scan_row (scan_row),
        .scan_col (scan_col)
    );

    // Screen and shadow buffers live here, together with the tracked panel cursor.
    cldr_dp #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .rd_addr        (rd_addr),
        .scan_idx       (scan_idx),
        .scan_row       (scan_row),
        .scan_col       (scan_col),
        .in_row         (in_row),
        .in_column      (in_column),
        .in_char_code   (in_char_code),
        .in_glyph_index (in_glyph_index),
        .in_glyph_rows  (in_glyph_rows),
        .stat           (stat),
        .word           (word)
    );

    // The last byte of a refresh is only known once the scan ends, so each byte
    // waits as the pending word of the output stage until its last flag is settled.
    cldr_out u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .emit          (cmd.emit),
        .flush         (flush),
        .word          (word),
        .room          (room),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

/* verif/tb_char_lcd_diff_refresher.sv */
// Self-checking testbench for the character LCD diff refresher stream block.
`timescale 1ns / 1ps

module tb_char_lcd_diff_refresher
    import cldr_pkg::*;
();

    localparam int NCELLS       = ROWS_DEF * COLUMNS_DEF;
    localparam int RANDOM_ITEMS = 300;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 100;

    // Op codes that the block does not decode; they must leave no trace.
    localparam logic [2:0] OP_SPARE_5 = 3'd5;
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [2:0]  op;
        logic        row;
        logic [4:0]  column;
        logic [7:0]  char_code;
        logic [2:0]  glyph_index;
        logic [63:0] glyph_rows;
    } lcd_item_t;

    typedef struct packed {
        logic [7:0]        lcd_byte;
        logic              is_data;
        logic [WAIT_W-1:0] wait_us;
        logic              last;
    } lcd_beat_t;

    typedef struct packed {
        lcd_item_t item;
        logic      typed;
        lcd_beat_t first_beat;
    } table_row_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata  = '0;
    logic [2:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // Predictor state: what the user asked for, what the panel holds, and the cursor.
    logic [7:0] screen_img [0:NCELLS-1];
    logic [7:0] shadow_img [0:NCELLS-1];
    logic [5:0] cur_col;
    logic       cur_row;
    logic       cur_known;

    lcd_beat_t  pending_words [$];
    table_row_t directed_rows [$];
    int         errors      = 0;
    int         cycle_count = 0;
    bit         steady      = 1'b0;
    int         run_col     = 0;
    logic       run_row     = 1'b0;

    always #2 clk = ~clk;

    char_lcd_diff_refresher dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    function automatic lcd_beat_t make_beat(input logic [7:0] b, input logic d,
                                            input logic [WAIT_W-1:0] w, input logic l);
        lcd_beat_t x;
        x.lcd_byte = b;
        x.is_data  = d;
        x.wait_us  = w;
        x.last     = l;
        return x;
    endfunction

    task automatic queue_word(input logic [7:0] b, input logic d, input logic [WAIT_W-1:0] w);
        pending_words.push_back(make_beat(b, d, w, 1'b0));
    endtask

    task automatic reset_lcd_image();
        for (int i = 0; i < NCELLS; i++) begin
            screen_img[i] = CHAR_SPACE;
            shadow_img[i] = CHAR_SPACE;
        end
        cur_col   = '0;
        cur_row   = 1'b0;
        cur_known = 1'b0;
    endtask

    task automatic clear_lcd_image();
        queue_word(CMD_CLEAR, 1'b0, WAIT_CLEAR);
        for (int i = 0; i < NCELLS; i++) begin
            screen_img[i] = CHAR_SPACE;
            shadow_img[i] = CHAR_SPACE;
        end
        cur_col   = '0;
        cur_row   = 1'b0;
        cur_known = 1'b1;
    endtask

    // Appends the LCD words one accepted item causes and marks the final one.
    task automatic predict_lcd_words(input lcd_item_t it);
        int         base;
        int         c;
        int         start;
        logic [7:0] addr;
        base = pending_words.size();
        case (it.op)
            OP_WRITE_CELL:
                if (it.row < ROWS_DEF && it.column < COLUMNS_DEF)
                    screen_img[it.row * COLUMNS_DEF + it.column] = it.char_code;
            OP_REFRESH:
                for (int r = 0; r < ROWS_DEF; r++) begin
                    c = 0;
                    while (c < COLUMNS_DEF) begin
                        if (screen_img[r * COLUMNS_DEF + c] == shadow_img[r * COLUMNS_DEF + c])
                        begin
                            c++;
                        end
                        else
                        begin
                            start = c;
                            while (c < COLUMNS_DEF &&
                                   screen_img[r * COLUMNS_DEF + c] !=
                                   shadow_img[r * COLUMNS_DEF + c])
                                c++;
                            // The address command is skipped only when the panel cursor
                            // is known to sit exactly at the start of this run.
                            if (!cur_known || cur_col != start || cur_row != r)
                            begin
                                addr = CMD_SET_DDRAM + (r != 0 ? DDRAM_ROW1 : 8'h00) + 8'(start);
                                queue_word(addr, 1'b0, WAIT_NORMAL);
                            end
                            for (int k = start; k < c; k++)
                            begin
                                shadow_img[r * COLUMNS_DEF + k] = screen_img[r * COLUMNS_DEF + k];
                                queue_word(screen_img[r * COLUMNS_DEF + k], 1'b1, WAIT_NORMAL);
                            end
                            cur_col   = 6'(c);
                            cur_row   = 1'(r);
                            cur_known = 1'b1;
                        end
                    end
                end
            OP_UPLOAD_GLYPH:
            begin
                queue_word(CMD_SET_CGRAM + {2'b00, it.glyph_index, 3'b000}, 1'b0, WAIT_NORMAL);
                for (int i = 0; i < 8; i++)
                    queue_word(it.glyph_rows[8*i +: 8], 1'b1, WAIT_NORMAL);
                cur_known = 1'b0;
            end
            OP_CLEAR:
                clear_lcd_image();
            OP_INIT:
            begin
                queue_word(CMD_FUNC_8BIT, 1'b0, WAIT_POWER_UP);
                queue_word(CMD_FUNC_8BIT, 1'b0, WAIT_SHORT);
                queue_word(CMD_FUNC_8BIT, 1'b0, WAIT_POWER_UP);
                queue_word(CMD_FUNC_2LINE, 1'b0, WAIT_NORMAL);
                queue_word(CMD_FUNC_2LINE, 1'b0, WAIT_NORMAL);
                queue_word(CMD_DISPLAY_OFF, 1'b0, WAIT_NORMAL);
                clear_lcd_image();
                queue_word(CMD_ENTRY_MODE, 1'b0, WAIT_NORMAL);
                queue_word(CMD_DISPLAY_ON, 1'b0, WAIT_NORMAL);
            end
            default:
                ;
        endcase
        if (pending_words.size() > base)
            pending_words[pending_words.size() - 1].last = 1'b1;
    endtask

    // Offers one word on the input side, with random idle cycles ahead of it, and
    // predicts its results at the edge where it is taken. A typed first word from the
    // directed table replaces the predicted one, so it is checked against the block.
    task automatic send_item(input lcd_item_t it, input logic typed, input lcd_beat_t first_beat);
        int base;
        while (!steady && $urandom_range(99) < 32)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.op;
        s_axis_tdata  <= {7'd0, it.glyph_rows, it.glyph_index, it.char_code, it.column, it.row};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        base = pending_words.size();
        predict_lcd_words(it);
        if (typed && pending_words.size() > base)
            pending_words[base] = first_beat;
    endtask

    // Holds the input side off until every predicted word has come out.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_words.size() != 0)
            @(posedge clk);
    endtask

    task automatic add_row(input logic [2:0] op, input logic row, input logic [4:0] column,
                           input logic [7:0] char_code, input logic [2:0] glyph_index,
                           input logic [63:0] glyph_rows, input logic typed,
                           input lcd_beat_t first_beat);
        table_row_t tr;
        tr.item.op          = op;
        tr.item.row         = row;
        tr.item.column      = column;
        tr.item.char_code   = char_code;
        tr.item.glyph_index = glyph_index;
        tr.item.glyph_rows  = glyph_rows;
        tr.typed            = typed;
        tr.first_beat       = first_beat;
        directed_rows.push_back(tr);
    endtask

    // Random item: mostly cell writes, often extending a run along a row so that
    // refreshes see multi-cell runs, with the other ops and spare codes mixed in.
    function automatic lcd_item_t random_item();
        lcd_item_t it;
        int        roll;
        int        pick;
        roll = $urandom_range(99);
        if (roll < 64)
            it.op = OP_WRITE_CELL;
        else if (roll < 80)
            it.op = OP_REFRESH;
        else if (roll < 86)
            it.op = OP_UPLOAD_GLYPH;
        else if (roll < 89)
            it.op = OP_CLEAR;
        else if (roll < 92)
            it.op = OP_INIT;
        else
        begin
            pick = $urandom_range(2);
            it.op = (pick == 0) ? OP_SPARE_5 : (pick == 1) ? OP_SPARE_6 : OP_SPARE_7;
        end
        roll = $urandom_range(99);
        if (roll < 12)
        begin
            it.column = 5'($urandom_range(31));
            it.row    = 1'($urandom_range(1));
        end
        else if (roll < 55)
        begin
            it.column = (run_col + 1 >= COLUMNS_DEF) ? 5'd0 : 5'(run_col + 1);
            it.row    = run_row;
        end
        else
        begin
            it.column = 5'($urandom_range(COLUMNS_DEF - 1));
            it.row    = 1'($urandom_range(1));
        end
        it.char_code   = ($urandom_range(99) < 20) ? CHAR_SPACE : 8'($urandom_range(255));
        it.glyph_index = 3'($urandom_range(7));
        it.glyph_rows  = {$urandom, $urandom};
        return it;
    endfunction

    // Output side: random stalls, and each word taken is held against the oldest
    // prediction field by field.
    initial
    begin
        lcd_beat_t want;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_words.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected word, byte %02h is_data %0d wait %0d last %0d",
                             $time, m_axis_tdata[7:0], m_axis_tuser[0], m_axis_tdata[20:8],
                             m_axis_tlast);
                end
                else
                begin
                    want = pending_words.pop_front();
                    if (m_axis_tdata[7:0] !== want.lcd_byte)
                    begin
                        errors++;
                        $display("%0t: lcd_byte expected %02h actual %02h",
                                 $time, want.lcd_byte, m_axis_tdata[7:0]);
                    end
                    if (m_axis_tuser[0] !== want.is_data)
                    begin
                        errors++;
                        $display("%0t: is_data expected %0d actual %0d",
                                 $time, want.is_data, m_axis_tuser[0]);
                    end
                    if (m_axis_tdata[20:8] !== want.wait_us)
                    begin
                        errors++;
                        $display("%0t: wait_us expected %0d actual %0d",
                                 $time, want.wait_us, m_axis_tdata[20:8]);
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        errors++;
                        $display("%0t: last expected %0d actual %0d",
                                 $time, want.last, m_axis_tlast);
                    end
                end
            end
            m_axis_tready <= steady || ($urandom_range(99) >= 32);
            @(posedge clk);
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** char_lcd_diff_refresher: FAILED **");
            $finish;
        end
    end

    initial
    begin
        lcd_item_t it;
        lcd_beat_t none;
        int        sent;
        bit        filled;
        bit        paused;
        none = make_beat(8'h00, 1'b0, '0, 1'b0);
        reset_lcd_image();

        // Directed table. A typed first word is given where it is plain from the spec.
        // Refresh right after reset: nothing differs, so no word at all.
        add_row(OP_REFRESH, 0, 0, 8'h00, 0, 64'h0, 0, none);
        // Corner cells with the extreme character codes.
        add_row(OP_WRITE_CELL, 0, 0, 8'h00, 0, 64'h0, 0, none);
        add_row(OP_WRITE_CELL, 1, 19, 8'hFF, 7, 64'hFFFF_FFFF_FFFF_FFFF, 0, none);
        // Writes outside the screen are dropped.
        add_row(OP_WRITE_CELL, 0, 20, 8'h41, 0, 64'h0, 0, none);
        add_row(OP_WRITE_CELL, 1, 31, 8'h42, 0, 64'h0, 0, none);
        // Cursor unknown after reset, so the first run starts with an address command.
        add_row(OP_REFRESH, 0, 0, 8'h00, 0, 64'h0, 1,
                make_beat(CMD_SET_DDRAM, 1'b0, WAIT_NORMAL, 1'b0));
        add_row(OP_WRITE_CELL, 0, 1, 8'h41, 0, 64'h0, 0, none);
        add_row(OP_REFRESH, 0, 0, 8'h00, 0, 64'h0, 0, none);
        // The cursor now sits right after the last run, so this one needs no address.
        add_row(OP_WRITE_CELL, 0, 2, 8'h42, 0, 64'h0, 0, none);
        add_row(OP_REFRESH, 0, 0, 8'h00, 0, 64'h0, 0, none);
        // Glyph uploads at both ends of the slot range; they make the cursor unknown.
        add_row(OP_UPLOAD_GLYPH, 0, 0, 8'h00, 0, 64'h0, 1,
                make_beat(CMD_SET_CGRAM, 1'b0, WAIT_NORMAL, 1'b0));
        add_row(OP_UPLOAD_GLYPH, 1, 31, 8'hFF, 7, 64'hFFFF_FFFF_FFFF_FFFF, 1,
                make_beat(CMD_SET_CGRAM + 8'h38, 1'b0, WAIT_NORMAL, 1'b0));
        add_row(OP_WRITE_CELL, 0, 3, 8'h43, 0, 64'h0, 0, none);
        add_row(OP_REFRESH, 0, 0, 8'h00, 0, 64'h0, 0, none);
        // Spare op codes do nothing.
        add_row(OP_SPARE_5, 1, 31, 8'hFF, 7, 64'hFFFF_FFFF_FFFF_FFFF, 0, none);
        add_row(OP_SPARE_6, 0, 0, 8'h00, 0, 64'h0, 0, none);
        add_row(OP_SPARE_7, 1, 5, 8'h5A, 3, 64'h0123_4567_89AB_CDEF, 0, none);
        // A pending change is thrown away by the clear.
        add_row(OP_WRITE_CELL, 1, 0, 8'h5A, 0, 64'h0, 0, none);
        add_row(OP_CLEAR, 0, 0, 8'h00, 0, 64'h0, 1,
                make_beat(CMD_CLEAR, 1'b0, WAIT_CLEAR, 1'b1));
        add_row(OP_REFRESH, 0, 0, 8'h00, 0, 64'h0, 0, none);
        // Cursor is homed by the clear, so a change at (0,0) goes out as bare data.
        add_row(OP_WRITE_CELL, 0, 0, 8'h31, 0, 64'h0, 0, none);
        add_row(OP_REFRESH, 0, 0, 8'h00, 0, 64'h0, 1,
                make_beat(8'h31, 1'b1, WAIT_NORMAL, 1'b1));
        add_row(OP_INIT, 0, 0, 8'h00, 0, 64'h0, 1,
                make_beat(CMD_FUNC_8BIT, 1'b0, WAIT_POWER_UP, 1'b0));
        // Writing a space over a space is no change.
        add_row(OP_WRITE_CELL, 0, 5, CHAR_SPACE, 0, 64'h0, 0, none);
        add_row(OP_REFRESH, 0, 0, 8'h00, 0, 64'h0, 0, none);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].first_beat);

        wait_drained();

        // Random part, with a stretch free of stalls on both sides, one full-screen
        // repaint and one more full drain along the way.
        sent   = 0;
        filled = 1'b0;
        paused = 1'b0;
        while (sent < RANDOM_ITEMS)
        begin
            steady = (sent >= 60 && sent < 140);
            if (!filled && sent >= 150)
            begin
                filled = 1'b1;
                for (int r = 0; r < ROWS_DEF; r++)
                    for (int c = 0; c < COLUMNS_DEF; c++)
                    begin
                        it           = random_item();
                        it.op        = OP_WRITE_CELL;
                        it.row       = 1'(r);
                        it.column    = 5'(c);
                        it.char_code = 8'($urandom_range(255, 33));
                        send_item(it, 1'b0, none);
                    end
                it    = random_item();
                it.op = OP_REFRESH;
                send_item(it, 1'b0, none);
                sent += NCELLS + 1;
            end
            else if (!paused && sent >= 230)
            begin
                paused = 1'b1;
                wait_drained();
            end
            else
            begin
                it = random_item();
                if (it.op == OP_WRITE_CELL)
                begin
                    run_col = it.column;
                    run_row = it.row;
                end
                send_item(it, 1'b0, none);
                sent++;
            end
        end
        steady = 1'b0;

        wait_drained();
        // Give any stray word time to show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending_words.size() == 0)
            $display("** char_lcd_diff_refresher: PASSED **");
        else
            $display("** char_lcd_diff_refresher: FAILED **");
        $finish;
    end

endmodule

/* char_lcd_diff_refresher.f */
rtl/core/cldr_pkg.sv
rtl/core/cldr_dp.sv
rtl/core/cldr_out.sv
rtl/core/cldr_ctrl.sv
rtl/core/char_lcd_diff_refresher.sv
verif/tb_char_lcd_diff_refresher.sv
